/* src/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/ipid_pkg.sv */
// ---------------------------------------------------------------------------
// ipid_pkg
// types and constants shared by the clamped incremental pid controller
// ---------------------------------------------------------------------------
package ipid_pkg;

  localparam int GAIN_W      = 16;
  localparam int DRIVE_W     = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int DRIVE_MAX   = 100;
  localparam int DRIVE_MIN   = -100;

  localparam logic [CFG_INDEX_W-1:0] REG_KP_GAIN = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_KI_GAIN = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KD_GAIN = 2'd2;

  typedef logic signed [GAIN_W-1:0] gain_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      sat;
  } drive_result_t;

endpackage

/* src/pid_in_if.sv */
// ---------------------------------------------------------------------------
// pid_in_if
// input channel: measured value and target per control step
// ---------------------------------------------------------------------------
interface pid_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] measured_value;
  logic signed [SAMPLE_WIDTH-1:0] target_value;

  modport source (output valid, output measured_value, output target_value, input ready);
  modport sink   (input valid, input measured_value, input target_value, output ready);
endinterface

/* src/pid_out_if.sv */
// ---------------------------------------------------------------------------
// pid_out_if
// output channel: clamped drive value and saturation flag
// ---------------------------------------------------------------------------
interface pid_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] drive_value;
  logic              saturated;

  modport source (output valid, output drive_value, output saturated, input ready);
  modport sink   (input valid, input drive_value, input saturated, output ready);
endinterface

/* src/incremental_pid_clamped.sv */
// ---------------------------------------------------------------------------
// incremental_pid_clamped
// velocity-form pid controller with output clamped to +/-100
// ---------------------------------------------------------------------------
// Takes one item per clock cycle while the output is not stalled. The error
// is formed into an input register; from there the three gain products, the
// truncation, the accumulate and the clamp run in one pass into the result
// register, which also updates the accumulator and the error history, so
// consecutive items see each other's state with no gap. A stalled output
// holds one result and the input register one more item. The user writes
// gains through cfg_wr_en/cfg_index/cfg_data only while idle; the block
// does not enforce it.
`include "assert_macros.svh"

module incremental_pid_clamped
  import ipid_pkg::*;
#(
  parameter int SAMPLE_WIDTH       = 16,
  parameter int GAIN_FRACTION_BITS = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]      cfg_data,
  pid_in_if.sink                 in_ch,
  pid_out_if.source              out_ch
);

  gain_t                        kp_gain;
  gain_t                        ki_gain;
  gain_t                        kd_gain;
  logic signed [DRIVE_W-1:0]    acc;
  logic signed [SAMPLE_WIDTH:0] err1;
  logic signed [SAMPLE_WIDTH:0] err2;
  logic                         s1_valid;
  logic signed [SAMPLE_WIDTH:0] s1_err;
  logic                         out_valid;
  drive_result_t                out_res;
  drive_result_t                res_next;
  logic                         move;
  logic                         accept;

  assign move   = s1_valid && (!out_valid || out_ch.ready);
  assign accept = in_ch.valid && in_ch.ready;

  assign in_ch.ready        = !s1_valid || move;
  assign out_ch.valid       = out_valid;
  assign out_ch.drive_value = out_res.drive;
  assign out_ch.saturated   = out_res.sat;

  ipid_core #(
    .SAMPLE_WIDTH      (SAMPLE_WIDTH),
    .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
  ) u_core (
    .kp_gain(kp_gain),
    .ki_gain(ki_gain),
    .kd_gain(kd_gain),
    .err    (s1_err),
    .err1   (err1),
    .err2   (err2),
    .acc    (acc),
    .res    (res_next)
  );

  // gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain <= '0;
      ki_gain <= '0;
      kd_gain <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_KP_GAIN: kp_gain <= cfg_data;
        REG_KI_GAIN: ki_gain <= cfg_data;
        REG_KD_GAIN: kd_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage holds the error of the next item
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_err <= (SAMPLE_WIDTH + 1)'(in_ch.target_value)
              - (SAMPLE_WIDTH + 1)'(in_ch.measured_value);
    end
  end

  // controller state advances as the item enters the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      err1      <= '0;
      err2      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (move) begin
        acc       <= res_next.drive;
        err1      <= s1_err;
        err2      <= err1;
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_res <= res_next;
    end
  end

  `ASSERT_IMPL(a_drive_range, out_valid,
    out_res.drive <= DRIVE_W'(DRIVE_MAX) && out_res.drive >= DRIVE_W'(DRIVE_MIN))
  `ASSERT_IMPL(a_sat_at_limit, out_valid && out_res.sat,
    out_res.drive == DRIVE_W'(DRIVE_MAX) || out_res.drive == DRIVE_W'(DRIVE_MIN))
  `ASSERT_NEXT(a_acc_tracks_out, move, acc == out_res.drive && err1 == $past(s1_err))
  `ASSERT_NEXT(a_s1_held, s1_valid && !move, s1_valid && $stable(s1_err))

endmodule

/* src/ipid_core.sv */
// ---------------------------------------------------------------------------
// ipid_core
// increment from gains and error history, accumulate and clamp
// ---------------------------------------------------------------------------
module ipid_core
  import ipid_pkg::*;
#(
  parameter int SAMPLE_WIDTH       = 16,
  parameter int GAIN_FRACTION_BITS = 8
) (
  input  gain_t                       kp_gain,
  input  gain_t                       ki_gain,
  input  gain_t                       kd_gain,
  input  logic signed [SAMPLE_WIDTH:0] err,
  input  logic signed [SAMPLE_WIDTH:0] err1,
  input  logic signed [SAMPLE_WIDTH:0] err2,
  input  logic signed [DRIVE_W-1:0]   acc,
  output drive_result_t               res
);

  localparam int D1W  = SAMPLE_WIDTH + 2;
  localparam int D2W  = SAMPLE_WIDTH + 3;
  localparam int PW   = GAIN_W + D2W;
  localparam int SUMW = PW + 2;
  localparam int ACCW = SUMW + 1;
  localparam int RND  = (1 << GAIN_FRACTION_BITS) - 1;

  logic signed [D1W-1:0]  d1;
  logic signed [D2W-1:0]  d2;
  logic signed [PW-1:0]   p_term;
  logic signed [PW-1:0]   i_term;
  logic signed [PW-1:0]   d_term;
  logic signed [SUMW-1:0] sum;
  logic signed [SUMW-1:0] inc;
  logic signed [ACCW-1:0] acc_sum;
  logic                   over_hi;
  logic                   over_lo;

  always_comb begin
    d1 = D1W'(err) - D1W'(err1);
    d2 = D2W'(err) - (D2W'(err1) <<< 1) + D2W'(err2);
    p_term = PW'(kp_gain) * PW'(d1);
    i_term = PW'(ki_gain) * PW'(err);
    d_term = PW'(kd_gain) * PW'(d2);
    sum = SUMW'(p_term) + SUMW'(i_term) + SUMW'(d_term);
    // bias negative sums so the shift truncates toward zero
    inc = (sum + (sum[SUMW-1] ? SUMW'(RND) : SUMW'(0))) >>> GAIN_FRACTION_BITS;
    acc_sum = ACCW'(acc) + ACCW'(inc);
    over_hi = acc_sum > ACCW'(DRIVE_MAX);
    over_lo = acc_sum < ACCW'(DRIVE_MIN);
    res.sat = over_hi || over_lo;
    if (over_hi) begin
      res.drive = DRIVE_W'(DRIVE_MAX);
    end else if (over_lo) begin
      res.drive = DRIVE_W'(DRIVE_MIN);
    end else begin
      res.drive = acc_sum[DRIVE_W-1:0];
    end
  end

endmodule

/* tb/sv/incremental_pid_clamped_tb.sv */
// ---------------------------------------------------------------------------
// incremental_pid_clamped_tb
// self-checking bench for the clamped velocity-form pid controller
// ---------------------------------------------------------------------------
// A queue of control steps feeds a clocked driver with random gaps. A clocked
// monitor applies random back-pressure and compares every drive result with
// the value a local pid model predicts when the step is accepted. Gains are
// rewritten between phases while the block is idle. A directed part covers
// field extremes, the clamp boundary, truncation and huge increments.
// ---------------------------------------------------------------------------
module incremental_pid_clamped_tb;
  import ipid_pkg::*;

  localparam int SAMPLE_W       = 16;
  localparam int FRAC_BITS      = 8;
  localparam int RAND_PHASES    = 8;
  localparam int STEPS_PER_PHASE = 54;
  localparam int QUIET_LIMIT    = 2000;
  localparam int DRAIN_CYCLES   = 6;

  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} idle_mode_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] meas;
    logic signed [SAMPLE_W-1:0] tgt;
    int unsigned                idle_after;
  } sample_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0]      cfg_data  = '0;

  logic                       send_valid = 1'b0;
  logic signed [SAMPLE_W-1:0] send_meas  = '0;
  logic signed [SAMPLE_W-1:0] send_tgt   = '0;
  logic                       recv_ready = 1'b0;

  pid_in_if #(.SAMPLE_WIDTH(SAMPLE_W)) in_ch();
  pid_out_if out_ch();

  assign in_ch.valid          = send_valid;
  assign in_ch.measured_value = send_meas;
  assign in_ch.target_value   = send_tgt;
  assign out_ch.ready         = recv_ready;

  incremental_pid_clamped #(
    .SAMPLE_WIDTH      (SAMPLE_W),
    .GAIN_FRACTION_BITS(FRAC_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  always #6 clk = ~clk;

  // controller model state
  gain_t gain_kp = '0;
  gain_t gain_ki = '0;
  gain_t gain_kd = '0;
  logic signed [DRIVE_W-1:0]  drive_acc = '0;
  logic signed [SAMPLE_W:0]   err_prev  = '0;
  logic signed [SAMPLE_W:0]   err_prev2 = '0;

  sample_t       sample_q[$];
  drive_result_t expected_drive_q[$];

  idle_mode_t  send_mode  = IDLE_NONE;
  idle_mode_t  stall_mode = IDLE_NONE;
  int unsigned send_wait  = 0;
  int unsigned recv_wait  = 0;
  int unsigned quiet_cycles = 0;
  int          error_count  = 0;
  int          steps_sent   = 0;
  int          results_seen = 0;
  int          gain_sets    = 0;

  function automatic int unsigned draw_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, 16);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  function automatic gain_t draw_gain();
    case ($urandom_range(0, 3))
      0:       return gain_t'($urandom);
      1:       return gain_t'(int'($urandom_range(0, 1024)) - 512);
      2:       return gain_t'(int'($urandom_range(0, 128)) - 64);
      default: return $urandom_range(0, 1) ? gain_t'(16'h7fff) : gain_t'(16'h8000);
    endcase
  endfunction

  // one control step: error, exact increment, truncate toward zero, clamp
  task automatic predict_pid_step(input logic signed [SAMPLE_W-1:0] meas,
                                  input logic signed [SAMPLE_W-1:0] tgt);
    longint        err, d1, d2, prod_sum, incr, nxt;
    drive_result_t res;
    err      = longint'(tgt) - longint'(meas);
    d1       = err - longint'(err_prev);
    d2       = err - 2 * longint'(err_prev) + longint'(err_prev2);
    prod_sum = longint'(gain_kp) * d1 + longint'(gain_ki) * err + longint'(gain_kd) * d2;
    incr     = prod_sum / (longint'(1) << FRAC_BITS);
    nxt      = longint'(drive_acc) + incr;
    res.sat  = 1'b0;
    if (nxt > DRIVE_MAX) begin
      nxt     = DRIVE_MAX;
      res.sat = 1'b1;
    end else if (nxt < DRIVE_MIN) begin
      nxt     = DRIVE_MIN;
      res.sat = 1'b1;
    end
    res.drive = DRIVE_W'(nxt);
    drive_acc = res.drive;
    err_prev2 = err_prev;
    err_prev  = err[SAMPLE_W:0];
    expected_drive_q.push_back(res);
  endtask

  always @(posedge clk) begin : drive_samples
    sample_t nxt;
    if (rst) begin
      send_valid <= 1'b0;
      send_wait  <= 0;
    end else begin
      if (send_valid && in_ch.ready) begin
        predict_pid_step(send_meas, send_tgt);
        steps_sent++;
      end
      if (!send_valid || in_ch.ready) begin
        if (send_wait != 0) begin
          send_valid <= 1'b0;
          send_wait  <= send_wait - 1;
        end else if (sample_q.size() != 0) begin
          nxt = sample_q.pop_front();
          send_valid <= 1'b1;
          send_meas  <= nxt.meas;
          send_tgt   <= nxt.tgt;
          send_wait  <= nxt.idle_after;
        end else begin
          send_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_drive
    drive_result_t want;
    int unsigned   w;
    if (rst) begin
      recv_ready <= 1'b0;
      recv_wait  <= 0;
    end else begin
      if (out_ch.valid && recv_ready) begin
        results_seen++;
        if (expected_drive_q.size() == 0) begin
          $display("%0t: result with nothing expected: drive %0d sat %0b",
                   $time, out_ch.drive_value, out_ch.saturated);
          error_count++;
        end else begin
          want = expected_drive_q.pop_front();
          if (out_ch.drive_value !== want.drive) begin
            $display("%0t: drive_value expected %0d actual %0d",
                     $time, want.drive, out_ch.drive_value);
            error_count++;
          end
          if (out_ch.saturated !== want.sat) begin
            $display("%0t: saturated expected %0b actual %0b",
                     $time, want.sat, out_ch.saturated);
            error_count++;
          end
        end
        w = draw_idle(stall_mode);
        recv_wait  <= w;
        recv_ready <= (w == 0);
      end else if (recv_wait != 0) begin
        recv_wait  <= recv_wait - 1;
        recv_ready <= (recv_wait == 1);
      end else begin
        recv_ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (send_valid && in_ch.ready) || (out_ch.valid && recv_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_sample(input logic signed [SAMPLE_W-1:0] meas,
                              input logic signed [SAMPLE_W-1:0] tgt);
    sample_t s;
    s.meas       = meas;
    s.tgt        = tgt;
    s.idle_after = draw_idle(send_mode);
    sample_q.push_back(s);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input gain_t val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_KP_GAIN: gain_kp = val;
      REG_KI_GAIN: gain_ki = val;
      REG_KD_GAIN: gain_kd = val;
      default: ;
    endcase
  endtask

  task automatic set_gains(input gain_t kp, input gain_t ki, input gain_t kd);
    write_reg(REG_KP_GAIN, kp);
    write_reg(REG_KI_GAIN, ki);
    write_reg(REG_KD_GAIN, kd);
    gain_sets++;
  endtask

  // all items in, all results out, then let the pipeline settle
  task automatic wait_drained();
    while (sample_q.size() != 0 || send_valid || expected_drive_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    logic [SAMPLE_W-1:0] m, t;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // gains still at reset: output must stay at zero
    send_mode  = IDLE_SPARSE;
    stall_mode = IDLE_SPARSE;
    queue_sample(16'sh8000, 16'sh7fff);
    queue_sample(16'sh7fff, 16'sh8000);
    queue_sample(16'sd0, 16'sd0);
    wait_drained();

    // integral only with unity gain: walk onto and past both limits
    set_gains(16'sd0, 16'sd256, 16'sd0);
    queue_sample(16'sd0, 16'sd100);
    queue_sample(16'sd0, 16'sd0);
    queue_sample(16'sd0, 16'sd1);
    queue_sample(16'sd0, -16'sd200);
    queue_sample(16'sd0, -16'sd1);
    queue_sample(16'sd0, 16'sd0);
    queue_sample(16'sd0, 16'sd100);
    wait_drained();

    // tiny gain: negative fractions truncate toward zero, not down
    set_gains(16'sd0, 16'sd1, 16'sd0);
    queue_sample(16'sd0, -16'sd255);
    queue_sample(16'sd0, 16'sd255);
    queue_sample(16'sd0, -16'sd512);
    queue_sample(16'sd0, 16'sd512);
    wait_drained();

    // most negative gains on full-swing errors, plus a write to no register
    set_gains(16'sh8000, 16'sh8000, 16'sh8000);
    write_reg(REG_UNUSED, 16'h7fff);
    send_mode  = IDLE_NONE;
    stall_mode = IDLE_NONE;
    queue_sample(16'sh7fff, 16'sh8000);
    queue_sample(16'sh8000, 16'sh7fff);
    queue_sample(16'sh7fff, 16'sh8000);
    queue_sample(16'sh8000, 16'sh7fff);
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      send_mode  = idle_mode_t'(ph % 3);
      stall_mode = idle_mode_t'((ph + ph / 3) % 3);
      if (ph == 0)
        set_gains(16'sh7fff, 16'sh7fff, 16'sh7fff);
      else if (ph == 1)
        set_gains(16'sh8000, 16'sh8000, 16'sh8000);
      else
        set_gains(draw_gain(), draw_gain(), draw_gain());
      if (ph % 2 == 1)
        write_reg(REG_UNUSED, gain_t'($urandom));
      for (int k = 0; k < STEPS_PER_PHASE; k++) begin
        m = SAMPLE_W'($urandom);
        case ($urandom_range(0, 3))
          0:       t = SAMPLE_W'($urandom);
          1, 2:    t = m + SAMPLE_W'($urandom_range(0, 64)) - SAMPLE_W'(32);
          default: t = m;
        endcase
        queue_sample(m, t);
      end
      wait_drained();
    end

    $display("ran %0d control steps across %0d gain settings, %0d results compared",
             steps_sent, gain_sets, results_seen);
    $display("included clamp edges, truncation of negative increments and extreme gains");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
